// File: rtl/core/prime_gap_residue_histogram_top_macros.svh
// assertion macros shared by the rtl files of the histogram block
// expects clk and arst_n in the scope of each use
`ifndef PRIME_GAP_RESIDUE_HISTOGRAM_TOP_MACROS_SVH
`define PRIME_GAP_RESIDUE_HISTOGRAM_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define PGRH_ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define PGRH_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/pgrh_pkg.sv
// shared types and constants of the prime gap residue histogram block
// no dependencies
package pgrh_pkg;

	// action codes
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// table select codes
	localparam logic [2:0] SEL_MOD6     = 3'd0;
	localparam logic [2:0] SEL_MOD30    = 3'd1;
	localparam logic [2:0] SEL_MOD210   = 3'd2;
	localparam logic [2:0] SEL_MOD2310  = 3'd3;
	localparam logic [2:0] SEL_MOD30030 = 3'd4;
	localparam logic [2:0] SEL_GAP      = 3'd5;
	localparam logic [2:0] SEL_START    = 3'd6;

	localparam int unsigned MOD_TOP = 30030;
	// floor(2^40 / 30030)
	localparam longint unsigned MOD_TOP_RECIP = 64'd36613773;
	localparam int unsigned MOD_TOP_SHIFT = 40;

	// smaller moduli all divide 30030
	localparam int unsigned SMALL_MOD [4] = '{6, 30, 210, 2310};
	// floor(2^30 / m)
	localparam longint unsigned SMALL_RECIP [4] = '{178956970, 35791394, 5113056, 464823};
	localparam int unsigned SMALL_SHIFT = 30;

	// 256^i mod 30030
	localparam int unsigned BYTE_WEIGHT [8] =
		'{1, 256, 5476, 20476, 16636, 24586, 17746, 8446};

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PW = 4;

	typedef struct packed {
		logic [2:0]  r6;
		logic [4:0]  r30;
		logic [7:0]  r210;
		logic [11:0] r2310;
		logic [14:0] r30030;
	} res_t;

	typedef struct packed {
		logic bump;
		logic twice;
	} cnt_req_t;

endpackage

// File: rtl/core/pgrh_residue.sv
// five-stage pipeline giving a 64-bit number mod 6, 30, 210, 2310 and 30030
// depends on pgrh_pkg
module pgrh_residue
	import pgrh_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] value,
	output res_t        res
);

	logic [24:0] x_sum;
	logic [24:0] x_s2, x_s3;
	logic [50:0] prod3;
	logic [9:0]  q_s3;
	logic [15:0] t4;
	logic [14:0] r_s4, r_s5;
	logic [42:0] prod5 [4];
	logic [12:0] q_s5 [4];
	logic [15:0] t6 [4];
	logic [11:0] rm [4];

	// weighted byte sum, congruent to value mod 30030
	always_comb begin
		x_sum = '0;
		for (int i = 0; i < 8; i++) begin
			x_sum = x_sum + 25'(value[8*i +: 8]) * 25'(BYTE_WEIGHT[i]);
		end
	end

	assign prod3 = 51'(x_s2) * 51'(MOD_TOP_RECIP);
	assign t4 = 16'(x_s3 - 25'(q_s3) * 25'(MOD_TOP));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod5[k] = 43'(r_s4) * 43'(SMALL_RECIP[k]);
			t6[k] = 16'(r_s5) - 16'(q_s5[k]) * 16'(SMALL_MOD[k]);
			rm[k] = (t6[k] >= 16'(SMALL_MOD[k])) ? 12'(t6[k] - 16'(SMALL_MOD[k]))
				: 12'(t6[k]);
		end
	end

	always_ff @(posedge clk) begin
		x_s2 <= x_sum;
		x_s3 <= x_s2;
		q_s3 <= 10'(prod3 >> MOD_TOP_SHIFT);
		r_s4 <= (t4 >= 16'(MOD_TOP)) ? 15'(t4 - 16'(MOD_TOP)) : 15'(t4);
		r_s5 <= r_s4;
		for (int k = 0; k < 4; k++) begin
			q_s5[k] <= 13'(prod5[k] >> SMALL_SHIFT);
		end
		res.r6 <= rm[0][2:0];
		res.r30 <= rm[1][4:0];
		res.r210 <= rm[2][7:0];
		res.r2310 <= rm[3];
		res.r30030 <= r_s5;
	end

endmodule

// File: rtl/core/pgrh_cntmem.sv
// counter memory with registered read, saturating increment and write-back
// forwarding of the last write; depends on pgrh_pkg
module pgrh_cntmem
	import pgrh_pkg::*;
#(
	parameter int DEPTH = 6,
	parameter int CW = 32,
	parameter int CAW = 15,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr_en,
	input  logic [CAW-1:0] clr_addr,
	input  logic [AW-1:0]  addr,
	input  cnt_req_t       req,
	output logic [CW-1:0]  count
);

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rd_s1;
	logic [AW-1:0] addr_s1;
	cnt_req_t      req_s1;
	logic          fwd_we_q;
	logic [AW-1:0] fwd_addr_q;
	logic [CW-1:0] fwd_data_q;
	logic [CW-1:0] cur, nxt, wd;
	logic [AW-1:0] wa;
	logic          we, clr_hit;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		return (&c) ? c : c + CW'(1);
	endfunction

	assign cur = (fwd_we_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_s1;
	assign nxt = req_s1.twice ? sat_inc(sat_inc(cur)) : sat_inc(cur);
	assign clr_hit = {1'b0, clr_addr} < (CAW+1)'(DEPTH);
	assign we = clr_en ? clr_hit : req_s1.bump;
	assign wa = clr_en ? AW'(clr_addr) : addr_s1;
	assign wd = clr_en ? '0 : nxt;
	assign count = cur;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			fwd_we_q <= 1'b0;
		end else begin
			req_s1 <= req;
			fwd_we_q <= !clr_en && req_s1.bump;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= nxt;
	end

endmodule

// File: rtl/core/prime_gap_residue_histogram_top.sv
// top level of the prime gap residue histogram block
// depends on pgrh_pkg, pgrh_residue, pgrh_cntmem and the assertion macro header
//
// usage
//   request channel (req_valid / req_stall) carries one item per accepted edge:
//   action 0 records value from source, action 1 reads one table entry picked by
//   table_select, entry_index and column
//   response channel (rsp_valid / rsp_stall) returns read_data and in_range,
//   one item per read item, in request order; record items return nothing
//   throughput: one item per cycle while req_stall is low, set by the single
//   read-modify-write slot of each counter memory (read at stage 6, write back at
//   stage 7, last write forwarded)
//   a read result passes stage 1, the residue pipeline of 5 stages, the memory
//   read and the response queue before it is offered
//   reset: all counters and first gap starts are cleared by a pass that writes
//   one address per cycle over max(30030, MAX_GAP * NUM_SOURCES) addresses
//   (262144 at default parameters); req_stall stays high during that pass
//   stall: results wait in a 16-entry queue; after the clearing pass req_stall rises
//   only once 16 read items are accepted but not yet taken, so the block keeps flowing
`include "prime_gap_residue_histogram_top_macros.svh"
module prime_gap_residue_histogram_top
	import pgrh_pkg::*;
#(
	parameter int MAX_GAP = 4096,
	parameter int NUM_SOURCES = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [63:0] value,
	input  logic [7:0]  source,
	input  logic [2:0]  table_select,
	input  logic [14:0] entry_index,
	input  logic [5:0]  column,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] read_data,
	output logic        in_range
);

	localparam int GW = $clog2(MAX_GAP);
	localparam int SD = MAX_GAP * NUM_SOURCES;
	localparam int SAW = $clog2(SD);
	localparam int CLR_DEPTH = (SD > int'(MOD_TOP)) ? SD : int'(MOD_TOP);
	localparam int CAW = $clog2(CLR_DEPTH);

	typedef struct packed {
		logic          action;
		logic [2:0]    sel;
		logic [14:0]   idx;
		logic [5:0]    col;
		logic [7:0]    src;
		logic          gap_ok;
		logic          own_col;
		logic          twice;
		logic          in_range;
		logic [GW-1:0] g;
		logic [SAW-1:0] saddr;
		logic [63:0]   prev;
	} item_t;

	typedef struct packed {
		logic        in_range;
		logic [63:0] data;
	} rsp_t;

	// clearing pass
	logic           clr_q;
	logic [CAW-1:0] clr_cnt_q;

	// input stage
	logic        accept;
	logic        v_s1, action_s1;
	logic [63:0] value_s1, prev_s1, prev_q;
	logic [7:0]  src_s1;
	logic [2:0]  sel_s1;
	logic [14:0] idx_s1;
	logic [5:0]  col_s1;

	// item pipeline
	logic  v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t p_s2, p_s3, p_s4, p_s5, p_s6, p_s7;
	item_t p3_d;
	logic [63:0]   diff;
	logic          rng1;
	logic [GW-1:0] gi;
	logic [7:0]    colsrc;
	res_t          res_s6;

	// counter memories
	logic     rec6, rd6;
	cnt_req_t res_req, tot_req, src_req;
	logic [COUNT_WIDTH-1:0] cnt_m6, cnt_m30, cnt_m210, cnt_m2310, cnt_m30030;
	logic [COUNT_WIDTH-1:0] cnt_tot, cnt_src;

	// first gap start memory: valid bit over value
	logic [64:0]   fs_mem [MAX_GAP];
	logic [64:0]   fs_rd_s7, fs_cur, fs_wd;
	logic          fs_we, fs_fwd_we_q, fs_item_we;
	logic [GW-1:0] fs_wa, fs_fwd_addr_q;
	logic [64:0]   fs_fwd_data_q;

	// response queue
	rsp_t               fifo_mem [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PW:0]   fifo_cnt_q, crd_q;
	logic               push, pop, acc_read;
	logic [63:0]        sel_data;

	assign req_stall = clr_q || (crd_q == (FIFO_PW+1)'(FIFO_DEPTH));
	assign accept = req_valid && !req_stall;
	assign acc_read = accept && action == ACT_READ;

	// clear sweep after reset, one address per cycle across all memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + CAW'(1);
			if (clr_cnt_q == CAW'(CLR_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// stage 1: capture the item; previous number moves on every record item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			prev_q <= 64'd1;
		end else begin
			v_s1 <= accept;
			if (accept && action == ACT_RECORD) begin
				prev_q <= value;
			end
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		value_s1 <= value;
		prev_s1 <= prev_q;
		src_s1 <= source;
		sel_s1 <= table_select;
		idx_s1 <= entry_index;
		col_s1 <= column;
	end

	// stage 2: gap and range check
	assign diff = value_s1 - prev_s1;

	always_comb begin
		case (sel_s1)
			SEL_MOD6:     rng1 = idx_s1 < 15'(SMALL_MOD[0]);
			SEL_MOD30:    rng1 = idx_s1 < 15'(SMALL_MOD[1]);
			SEL_MOD210:   rng1 = idx_s1 < 15'(SMALL_MOD[2]);
			SEL_MOD2310:  rng1 = idx_s1 < 15'(SMALL_MOD[3]);
			SEL_MOD30030: rng1 = idx_s1 < 15'(MOD_TOP);
			SEL_GAP:      rng1 = (17'(idx_s1) < 17'(MAX_GAP))
				&& (9'(col_s1) < 9'(NUM_SOURCES));
			SEL_START:    rng1 = 17'(idx_s1) < 17'(MAX_GAP);
			default:      rng1 = 1'b0;
		endcase
	end

	// stage 3: gap index and source column address
	assign gi = (p_s2.action == ACT_READ) ? GW'(p_s2.idx) : p_s2.g;
	assign colsrc = (p_s2.action == ACT_READ) ? {2'b00, p_s2.col} : p_s2.src;

	always_comb begin
		p3_d = p_s2;
		p3_d.g = gi;
		p3_d.saddr = SAW'(gi) * SAW'(NUM_SOURCES) + SAW'(colsrc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		p_s2.action <= action_s1;
		p_s2.sel <= sel_s1;
		p_s2.idx <= idx_s1;
		p_s2.col <= col_s1;
		p_s2.src <= src_s1;
		p_s2.gap_ok <= (value_s1 > prev_s1) && (diff < 64'(MAX_GAP));
		p_s2.own_col <= (src_s1 != 8'd0) && (9'(src_s1) < 9'(NUM_SOURCES));
		p_s2.twice <= src_s1 == 8'd0;
		p_s2.in_range <= rng1;
		p_s2.g <= GW'(diff);
		p_s2.saddr <= '0;
		p_s2.prev <= prev_s1;

		p_s3 <= p3_d;

		p_s4 <= p_s3;
		p_s5 <= p_s4;
		p_s6 <= p_s5;
		p_s7 <= p_s6;
	end

	// residues run alongside stages 2 to 6
	pgrh_residue u_residue (
		.clk   (clk),
		.value (value_s1),
		.res   (res_s6)
	);

	// stage 6 issues the memory reads, stage 7 writes back
	assign rec6 = v_s6 && p_s6.action == ACT_RECORD;
	assign rd6 = p_s6.action == ACT_READ;

	always_comb begin
		res_req.bump = rec6;
		res_req.twice = 1'b0;
		tot_req.bump = rec6 && p_s6.gap_ok;
		// source zero owns the total column, so it counts there twice
		tot_req.twice = p_s6.twice;
		src_req.bump = rec6 && p_s6.gap_ok && p_s6.own_col;
		src_req.twice = 1'b0;
	end

	pgrh_cntmem #(.DEPTH(6), .CW(COUNT_WIDTH), .CAW(CAW)) u_m6 (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(rd6 ? p_s6.idx[2:0] : res_s6.r6), .req(res_req), .count(cnt_m6)
	);

	pgrh_cntmem #(.DEPTH(30), .CW(COUNT_WIDTH), .CAW(CAW)) u_m30 (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(rd6 ? p_s6.idx[4:0] : res_s6.r30), .req(res_req), .count(cnt_m30)
	);

	pgrh_cntmem #(.DEPTH(210), .CW(COUNT_WIDTH), .CAW(CAW)) u_m210 (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(rd6 ? p_s6.idx[7:0] : res_s6.r210), .req(res_req), .count(cnt_m210)
	);

	pgrh_cntmem #(.DEPTH(2310), .CW(COUNT_WIDTH), .CAW(CAW)) u_m2310 (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(rd6 ? p_s6.idx[11:0] : res_s6.r2310), .req(res_req), .count(cnt_m2310)
	);

	pgrh_cntmem #(.DEPTH(30030), .CW(COUNT_WIDTH), .CAW(CAW)) u_m30030 (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(rd6 ? p_s6.idx : res_s6.r30030), .req(res_req), .count(cnt_m30030)
	);

	// total column of the gap counts
	pgrh_cntmem #(.DEPTH(MAX_GAP), .CW(COUNT_WIDTH), .CAW(CAW)) u_gap_tot (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(p_s6.g), .req(tot_req), .count(cnt_tot)
	);

	// per-source columns, row per gap; column zero of this memory is unused
	pgrh_cntmem #(.DEPTH(SD), .CW(COUNT_WIDTH), .CAW(CAW)) u_gap_src (
		.clk(clk), .arst_n(arst_n), .clr_en(clr_q), .clr_addr(clr_cnt_q),
		.addr(p_s6.saddr), .req(src_req), .count(cnt_src)
	);

	// first gap start: set once, never overwritten
	assign fs_cur = (fs_fwd_we_q && fs_fwd_addr_q == p_s7.g) ? fs_fwd_data_q : fs_rd_s7;
	assign fs_item_we = v_s7 && p_s7.action == ACT_RECORD && p_s7.gap_ok && !fs_cur[64];
	assign fs_we = clr_q ? ((CAW+1)'(clr_cnt_q) < (CAW+1)'(MAX_GAP)) : fs_item_we;
	assign fs_wa = clr_q ? GW'(clr_cnt_q) : p_s7.g;
	assign fs_wd = clr_q ? '0 : {1'b1, p_s7.prev};

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_wa] <= fs_wd;
		end
		fs_rd_s7 <= fs_mem[p_s6.g];
		fs_fwd_addr_q <= p_s7.g;
		fs_fwd_data_q <= fs_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_fwd_we_q <= 1'b0;
		end else begin
			fs_fwd_we_q <= !clr_q && fs_item_we;
		end
	end

	// stage 7: pick the read result
	always_comb begin
		case (p_s7.sel)
			SEL_MOD6:     sel_data = 64'(cnt_m6);
			SEL_MOD30:    sel_data = 64'(cnt_m30);
			SEL_MOD210:   sel_data = 64'(cnt_m210);
			SEL_MOD2310:  sel_data = 64'(cnt_m2310);
			SEL_MOD30030: sel_data = 64'(cnt_m30030);
			SEL_GAP:      sel_data = (p_s7.col == 6'd0) ? 64'(cnt_tot) : 64'(cnt_src);
			SEL_START:    sel_data = fs_cur[64] ? fs_cur[63:0] : 64'd0;
			default:      sel_data = 64'd0;
		endcase
	end

	// response queue, sized by the credit count so it never overflows
	assign push = v_s7 && p_s7.action == ACT_READ;
	assign rsp_valid = fifo_cnt_q != '0;
	assign pop = rsp_valid && !rsp_stall;
	assign read_data = fifo_mem[rd_ptr_q].data;
	assign in_range = fifo_mem[rd_ptr_q].in_range;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q].in_range <= p_s7.in_range;
			fifo_mem[wr_ptr_q].data <= p_s7.in_range ? sel_data : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
			crd_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + (FIFO_PW+1)'(push) - (FIFO_PW+1)'(pop);
			crd_q <= crd_q + (FIFO_PW+1)'(acc_read) - (FIFO_PW+1)'(pop);
		end
	end

	`PGRH_ASSERT_IMPLIES(a_push_not_full, push, fifo_cnt_q != (FIFO_PW+1)'(FIFO_DEPTH), "response queue overflow")
	`PGRH_ASSERT_HOLDS(a_fifo_within_credit, fifo_cnt_q <= crd_q, "queue holds more than credited")
	`PGRH_ASSERT_IMPLIES(a_clear_idle, clr_q, !(v_s1 || v_s6 || v_s7) && crd_q == '0, "item during clear")

endmodule
